// ===== rtl/rlpc_pkg.sv =====
// Package for the RGB lamp pattern controller: mode and action codes, last
// phase numbers, version numbers and the reset value of the timer unit register.
// No dependencies.
`default_nettype none

package rlpc_pkg;

    typedef enum logic [2:0] {
        MODE_OFF      = 3'd0,
        MODE_VARY     = 3'd1,
        MODE_TO_VARY  = 3'd2,
        MODE_FADE     = 3'd3,
        MODE_TO_FADE  = 3'd4,
        MODE_FADE_OFF = 3'd5
    } mode_t;

    typedef enum logic [2:0] {
        ACT_TICK      = 3'd0,
        ACT_SET_COLOR = 3'd1,
        ACT_VARY_REQ  = 3'd2,
        ACT_FADE_REQ  = 3'd3,
        ACT_TIMER_SET = 3'd4,
        ACT_VERSION   = 3'd5
    } action_t;

    // variation phases 0..5, fade phases 0..11
    localparam logic [2:0] VARY_LAST_PHASE = 3'd5;
    localparam logic [3:0] FADE_LAST_PHASE = 4'd11;

    localparam logic [7:0]  VERSION_MAJOR    = 8'd1;
    localparam logic [7:0]  VERSION_MINOR    = 8'd1;
    localparam logic [15:0] MS_PER_UNIT_INIT = 16'd60000;

endpackage : rlpc_pkg

`default_nettype wire

// ===== rtl/rgb_lamp_pattern_controller_core.sv =====
// RGB lamp pattern controller core: input register, one pass of update logic
// over the lamp state, result register. Depends on rlpc_pkg.
`default_nettype none

// Usage: every accepted request (tick, set color, variation or fade request,
// timer set, version query) produces exactly one result that reports the lamp
// levels and mode after the update. The block takes one request per clock
// cycle for as long as results are taken; an accepted request is held in the
// input register, goes through the single update pass and loads the result
// register once that register is empty or being taken. The lamp state
// is written in the same cycle the result register loads, so the next request
// sees it at once. The timer limit (armed units times ms_per_timer_unit) is
// kept in a register of its own, recomputed whenever either factor changes, so
// a tick only subtracts and compares. Write ms_per_timer_unit only while no
// request is in flight.
module rgb_lamp_pattern_controller_core #(
    parameter int MAX_LEVEL = 255
) (
    input  wire                     clk,
    input  wire                     rst_n,
    // configuration
    input  wire                     cfg_we,
    input  wire  [15:0]             cfg_wdata,
    // request channel
    input  wire                     in_valid,
    output logic                    in_stall,
    input  wire  [2:0]              action,
    input  wire  [7:0]              red_in,
    input  wire  [7:0]              green_in,
    input  wire  [7:0]              blue_in,
    input  wire  [15:0]             timer_minutes,
    input  wire  [31:0]             now_ms,
    // result channel
    output logic                    out_valid,
    input  wire                     out_stall,
    output logic [7:0]              red_level,
    output logic [7:0]              green_level,
    output logic [7:0]              blue_level,
    output logic [2:0]              mode_out,
    output logic                    version_valid,
    output logic [7:0]              version_major,
    output logic [7:0]              version_minor
);

    import rlpc_pkg::*;

    localparam logic [7:0] TOP = 8'(MAX_LEVEL);

    // ------------------------------------------------------------------
    // Configuration register and precomputed timer limit
    // ------------------------------------------------------------------
    logic [15:0] ms_unit_reg;
    logic [15:0] ms_unit_next;
    logic [31:0] limit_reg;
    logic [31:0] limit_next;

    // ------------------------------------------------------------------
    // Input register
    // ------------------------------------------------------------------
    logic        s1_valid_reg;
    logic [2:0]  s1_action_reg;
    logic [7:0]  s1_red_reg;
    logic [7:0]  s1_green_reg;
    logic [7:0]  s1_blue_reg;
    logic [15:0] s1_units_reg;
    logic [31:0] s1_now_reg;

    // ------------------------------------------------------------------
    // Lamp state
    // ------------------------------------------------------------------
    logic [7:0]  lamp_red_reg;
    logic [7:0]  lamp_green_reg;
    logic [7:0]  lamp_blue_reg;
    mode_t       mode_reg;
    logic [2:0]  vphase_reg;
    logic [3:0]  fphase_reg;
    logic [15:0] armed_reg;
    logic [15:0] pending_reg;
    logic [31:0] start_reg;

    logic [7:0]  lamp_red_next;
    logic [7:0]  lamp_green_next;
    logic [7:0]  lamp_blue_next;
    mode_t       mode_next;
    logic [2:0]  vphase_next;
    logic [3:0]  fphase_next;
    logic [15:0] armed_next;
    logic [15:0] pending_next;
    logic [31:0] start_next;
    logic        ver_next;

    // values computed for the request in the input register
    logic [7:0]  r_c;
    logic [7:0]  g_c;
    logic [7:0]  b_c;
    mode_t       mode_c;
    logic [2:0]  vphase_c;
    logic [3:0]  fphase_c;
    logic [15:0] armed_c;
    logic [15:0] pending_c;
    logic [31:0] start_c;
    logic [31:0] elapsed;

    // ------------------------------------------------------------------
    // Result register
    // ------------------------------------------------------------------
    logic        out_valid_reg;
    logic [7:0]  out_red_reg;
    logic [7:0]  out_green_reg;
    logic [7:0]  out_blue_reg;
    mode_t       out_mode_reg;
    logic        out_ver_reg;

    logic        s2_ready;
    logic        fire;
    logic        s1_ready;

    // Advance the result register when it is empty or being taken; the input
    // register moves on whenever its request is handed over.
    assign s2_ready = !out_valid_reg || !out_stall;
    assign fire     = s1_valid_reg && s2_ready;
    assign s1_ready = !s1_valid_reg || fire;
    assign in_stall = !s1_ready;

    assign elapsed = s1_now_reg - start_reg;

    // ------------------------------------------------------------------
    // Update pass: the whole step for one request
    // ------------------------------------------------------------------
    always_comb
    begin
        r_c       = lamp_red_reg;
        g_c       = lamp_green_reg;
        b_c       = lamp_blue_reg;
        mode_c    = mode_reg;
        vphase_c  = vphase_reg;
        fphase_c  = fphase_reg;
        armed_c   = armed_reg;
        pending_c = pending_reg;
        start_c   = start_reg;
        ver_next  = 1'b0;

        unique case (s1_action_reg)
            ACT_TICK:
            begin
                // expiry check comes before the mode step
                if (armed_reg != 16'd0 && elapsed > limit_reg)
                begin
                    mode_c  = MODE_FADE_OFF;
                    armed_c = 16'd0;
                end
                unique case (mode_c)
                    MODE_VARY:
                    begin
                        unique case (vphase_reg)
                            3'd0:
                            begin
                                g_c = g_c + 8'd1;
                                if (g_c == TOP) vphase_c = 3'd1;
                            end
                            3'd1:
                            begin
                                r_c = r_c - 8'd1;
                                if (r_c == 8'd0) vphase_c = 3'd2;
                            end
                            3'd2:
                            begin
                                b_c = b_c + 8'd1;
                                if (b_c == TOP) vphase_c = 3'd3;
                            end
                            3'd3:
                            begin
                                g_c = g_c - 8'd1;
                                if (g_c == 8'd0) vphase_c = 3'd4;
                            end
                            3'd4:
                            begin
                                r_c = r_c + 8'd1;
                                if (r_c == TOP) vphase_c = VARY_LAST_PHASE;
                            end
                            3'd5:
                            begin
                                b_c = b_c - 8'd1;
                                if (b_c == 8'd0) vphase_c = 3'd0;
                            end
                            default: ;
                        endcase
                    end
                    MODE_FADE:
                    begin
                        unique case (fphase_reg)
                            4'd0:
                            begin
                                r_c = r_c - 8'd1;
                                if (r_c == 8'd0) fphase_c = 4'd1;
                            end
                            4'd1:
                            begin
                                r_c = r_c + 8'd1;
                                g_c = g_c + 8'd1;
                                if (r_c == TOP) fphase_c = 4'd2;
                            end
                            4'd2:
                            begin
                                r_c = r_c - 8'd1;
                                g_c = g_c - 8'd1;
                                if (r_c == 8'd0) fphase_c = 4'd3;
                            end
                            4'd3:
                            begin
                                g_c = g_c + 8'd1;
                                if (g_c == TOP) fphase_c = 4'd4;
                            end
                            4'd4:
                            begin
                                g_c = g_c - 8'd1;
                                if (g_c == 8'd0) fphase_c = 4'd5;
                            end
                            4'd5:
                            begin
                                g_c = g_c + 8'd1;
                                b_c = b_c + 8'd1;
                                if (g_c == TOP) fphase_c = 4'd6;
                            end
                            4'd6:
                            begin
                                g_c = g_c - 8'd1;
                                b_c = b_c - 8'd1;
                                if (g_c == 8'd0) fphase_c = 4'd7;
                            end
                            4'd7:
                            begin
                                b_c = b_c + 8'd1;
                                if (b_c == TOP) fphase_c = 4'd8;
                            end
                            4'd8:
                            begin
                                b_c = b_c - 8'd1;
                                if (b_c == 8'd0) fphase_c = 4'd9;
                            end
                            4'd9:
                            begin
                                b_c = b_c + 8'd1;
                                r_c = r_c + 8'd1;
                                if (b_c == TOP) fphase_c = 4'd10;
                            end
                            4'd10:
                            begin
                                b_c = b_c - 8'd1;
                                r_c = r_c - 8'd1;
                                if (b_c == 8'd0) fphase_c = FADE_LAST_PHASE;
                            end
                            4'd11:
                            begin
                                r_c = r_c + 8'd1;
                                if (r_c == TOP) fphase_c = 4'd0;
                            end
                            default: ;
                        endcase
                    end
                    MODE_TO_VARY, MODE_TO_FADE:
                    begin
                        // ramp to full red, then start the pattern at phase 0
                        if (r_c < TOP)   r_c = r_c + 8'd1;
                        if (g_c > 8'd0)  g_c = g_c - 8'd1;
                        if (b_c > 8'd0)  b_c = b_c - 8'd1;
                        if (r_c == TOP && g_c == 8'd0 && b_c == 8'd0)
                        begin
                            if (mode_c == MODE_TO_VARY)
                            begin
                                mode_c   = MODE_VARY;
                                vphase_c = 3'd0;
                            end
                            else
                            begin
                                mode_c   = MODE_FADE;
                                fphase_c = 4'd0;
                            end
                        end
                    end
                    MODE_FADE_OFF:
                    begin
                        if (r_c > 8'd0) r_c = r_c - 8'd1;
                        if (g_c > 8'd0) g_c = g_c - 8'd1;
                        if (b_c > 8'd0) b_c = b_c - 8'd1;
                        if (r_c == 8'd0 && g_c == 8'd0 && b_c == 8'd0) mode_c = MODE_OFF;
                    end
                    default: ;
                endcase
            end
            ACT_SET_COLOR:
            begin
                r_c    = s1_red_reg;
                g_c    = s1_green_reg;
                b_c    = s1_blue_reg;
                mode_c = MODE_OFF;
            end
            ACT_VARY_REQ:
            begin
                if (mode_reg != MODE_VARY && mode_reg != MODE_TO_VARY)
                    mode_c = MODE_TO_VARY;
            end
            ACT_FADE_REQ:
            begin
                if (mode_reg != MODE_FADE && mode_reg != MODE_TO_FADE)
                    mode_c = MODE_TO_FADE;
            end
            ACT_TIMER_SET:
            begin
                pending_c = s1_units_reg;
                if (armed_reg != s1_units_reg)
                begin
                    armed_c = s1_units_reg;
                    start_c = s1_now_reg;
                end
            end
            ACT_VERSION:
            begin
                ver_next = 1'b1;
            end
            default: ;
        endcase

        // arm a pending timer after a color command or a pattern request
        if ((s1_action_reg == ACT_SET_COLOR || s1_action_reg == ACT_VARY_REQ ||
             s1_action_reg == ACT_FADE_REQ) &&
            armed_reg == 16'd0 && pending_reg != 16'd0)
        begin
            armed_c = pending_reg;
            start_c = s1_now_reg;
        end
    end

    // Commit the pass only when the request moves into the result register.
    always_comb
    begin
        if (fire)
        begin
            lamp_red_next   = r_c;
            lamp_green_next = g_c;
            lamp_blue_next  = b_c;
            mode_next       = mode_c;
            vphase_next     = vphase_c;
            fphase_next     = fphase_c;
            armed_next      = armed_c;
            pending_next    = pending_c;
            start_next      = start_c;
        end
        else
        begin
            lamp_red_next   = lamp_red_reg;
            lamp_green_next = lamp_green_reg;
            lamp_blue_next  = lamp_blue_reg;
            mode_next       = mode_reg;
            vphase_next     = vphase_reg;
            fphase_next     = fphase_reg;
            armed_next      = armed_reg;
            pending_next    = pending_reg;
            start_next      = start_reg;
        end
    end

    // Keep the limit in step with both of its factors.
    assign ms_unit_next = cfg_we ? cfg_wdata : ms_unit_reg;
    assign limit_next   = 32'(armed_next) * 32'(ms_unit_next);

    // ------------------------------------------------------------------
    // Control and state registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ms_unit_reg    <= MS_PER_UNIT_INIT;
            limit_reg      <= 32'd0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            lamp_red_reg   <= TOP;
            lamp_green_reg <= 8'd0;
            lamp_blue_reg  <= 8'd0;
            mode_reg       <= MODE_VARY;
            vphase_reg     <= 3'd0;
            fphase_reg     <= 4'd0;
            armed_reg      <= 16'd0;
            pending_reg    <= 16'd0;
            start_reg      <= 32'd0;
        end
        else
        begin
            ms_unit_reg    <= ms_unit_next;
            limit_reg      <= limit_next;
            if (s1_ready)
                s1_valid_reg <= in_valid;
            if (s2_ready)
                out_valid_reg <= s1_valid_reg;
            lamp_red_reg   <= lamp_red_next;
            lamp_green_reg <= lamp_green_next;
            lamp_blue_reg  <= lamp_blue_next;
            mode_reg       <= mode_next;
            vphase_reg     <= vphase_next;
            fphase_reg     <= fphase_next;
            armed_reg      <= armed_next;
            pending_reg    <= pending_next;
            start_reg      <= start_next;
        end
    end

    // ------------------------------------------------------------------
    // Payload registers: load the input on accept, the result on handover
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_action_reg <= action;
            s1_red_reg    <= red_in;
            s1_green_reg  <= green_in;
            s1_blue_reg   <= blue_in;
            s1_units_reg  <= timer_minutes;
            s1_now_reg    <= now_ms;
        end
        if (fire)
        begin
            out_red_reg   <= r_c;
            out_green_reg <= g_c;
            out_blue_reg  <= b_c;
            out_mode_reg  <= mode_c;
            out_ver_reg   <= ver_next;
        end
    end

    assign out_valid     = out_valid_reg;
    assign red_level     = out_red_reg;
    assign green_level   = out_green_reg;
    assign blue_level    = out_blue_reg;
    assign mode_out      = out_mode_reg;
    assign version_valid = out_ver_reg;
    assign version_major = out_ver_reg ? VERSION_MAJOR : 8'd0;
    assign version_minor = out_ver_reg ? VERSION_MINOR : 8'd0;

`ifndef SYNTH
    // the stored limit always matches the armed count and the unit setting
    assert property (@(posedge clk) disable iff (!rst_n)
        limit_reg == 32'(armed_reg) * 32'(ms_unit_reg))
        else $error("timer limit out of step with armed units");

    // phase counters never reach their unused codes
    assert property (@(posedge clk) disable iff (!rst_n)
        vphase_reg <= VARY_LAST_PHASE && fphase_reg <= FADE_LAST_PHASE)
        else $error("pattern phase out of range");

    // the lamp state moves only when a request is handed over
    assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(lamp_red_reg) && $stable(lamp_green_reg) &&
                  $stable(lamp_blue_reg) && $stable(armed_reg))
        else $error("lamp state changed without a request");

    // the input side stalls only while it holds a request it cannot pass on
    assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg && out_valid_reg && out_stall)
        else $error("input stalled without cause");
`endif

endmodule : rgb_lamp_pattern_controller_core

`default_nettype wire
